[design/skt_pkg.sv]
// Shared types and constants for the sorted key table.
// Used by every module of the block but skt_ram; depends on nothing.
`default_nettype none

package skt_pkg;

   localparam int CAPACITY    = 512;
   localparam int KEY_BITS    = 32;
   localparam int HANDLE_BITS = 32;
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 3;
   localparam int SLOT_BITS   = 9;
   localparam int IDX_BITS    = $clog2(CAPACITY);
   localparam int CNT_BITS    = $clog2(CAPACITY + 1);

   localparam logic REQ_FIND   = 1'b0;
   localparam logic REQ_INSERT = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_FOUND     = 3'd0,
      ST_MISS      = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_DUPLICATE = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]    key;
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // controller -> datapath
   typedef struct packed {
      logic       accept;     // latch request, open search window
      logic       rd_mid;     // read probe entry
      logic       rd_lo;      // read lower-bound entry
      logic       rd_last;    // read top entry, start of shift
      logic       rd_shift;   // read next entry down during shift
      logic       probe_step; // narrow search window
      logic       set_ptr;    // shift pointer to count
      logic       shift_wr;   // move entry up one place
      logic       new_wr;     // write new entry, bump count
      logic       res_load;   // capture pending result
      status_type res_status;
      logic       out_load;   // move pending result to output
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic lo_lt_hi;
      logic hit;
      logic is_insert;
      logic full;
      logic lo_eq_count;
      logic shift_last;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

[design/skt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module skt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

[design/skt_ctrl.sv]
// Sequencing state machine for search, shift and result hand-off.
// Depends on skt_pkg.
`default_nettype none

module skt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire skt_pkg::sts_type sts,
   output skt_pkg::cmd_type      cmd
);
   import skt_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_SEARCH = 7'b0000010,
      S_PROBE  = 7'b0000100,
      S_CHECK  = 7'b0001000,
      S_SHIFT  = 7'b0010000,
      S_WRITE  = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = ST_MISS;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (sts.lo_lt_hi) begin
               cmd.rd_mid = 1'b1;
               state_in   = S_PROBE;
            end else begin
               cmd.rd_lo = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_PROBE: begin
            cmd.probe_step = 1'b1;
            state_in       = S_SEARCH;
         end
         S_CHECK: begin
            priority if (!sts.is_insert) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = sts.hit ? ST_FOUND : ST_MISS;
               state_in       = S_DONE;
            end else if (sts.hit) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_DUPLICATE;
               state_in       = S_DONE;
            end else if (sts.full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_FULL;
               state_in       = S_DONE;
            end else if (sts.lo_eq_count) begin
               state_in = S_WRITE;
            end else begin
               cmd.rd_last = 1'b1;
               cmd.set_ptr = 1'b1;
               state_in    = S_SHIFT;
            end
         end
         S_SHIFT: begin
            cmd.shift_wr = 1'b1;
            if (sts.shift_last) begin
               state_in = S_WRITE;
            end else begin
               cmd.rd_shift = 1'b1;
            end
         end
         S_WRITE: begin
            cmd.new_wr     = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_INSERTED;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[design/skt_datapath.sv]
// Datapath: request latch, search window, shift pointer, entry count,
// entry RAM and result/output registers. Depends on skt_pkg and skt_ram.
`default_nettype none

module skt_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire skt_pkg::cmd_type                    cmd,
   output skt_pkg::sts_type                         sts,
   input  wire logic                                req_type,
   input  wire logic [skt_pkg::KEY_BITS-1:0]        req_key,
   input  wire logic [skt_pkg::KIND_BITS-1:0]       req_entry_kind,
   input  wire logic [skt_pkg::HANDLE_BITS-1:0]     req_entry_handle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [skt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic      [skt_pkg::SLOT_BITS-1:0]       rsp_slot_index,
   output logic      [skt_pkg::KIND_BITS-1:0]       rsp_found_kind,
   output logic      [skt_pkg::HANDLE_BITS-1:0]     rsp_found_handle
);
   import skt_pkg::*;

   // request latch
   logic                   type_ff;
   entry_type              new_ff;

   // search window, shift pointer, count
   logic [CNT_BITS-1:0]    lo_ff, lo_in;
   logic [CNT_BITS-1:0]    hi_ff, hi_in;
   logic [CNT_BITS-1:0]    ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    mid;

   // pending result and output register
   status_type             res_status_ff;
   logic [SLOT_BITS-1:0]   res_idx_ff;
   logic [KIND_BITS-1:0]   res_kind_ff;
   logic [HANDLE_BITS-1:0] res_handle_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             out_status_ff;
   logic [SLOT_BITS-1:0]   out_idx_ff;
   logic [KIND_BITS-1:0]   out_kind_ff;
   logic [HANDLE_BITS-1:0] out_handle_ff;

   // RAM ports
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   entry_type              wr_data;
   logic [IDX_BITS-1:0]    rd_addr;
   entry_type              rd_data;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_comb begin
      rd_addr = '0;
      priority if (cmd.rd_mid) begin
         rd_addr = mid[IDX_BITS-1:0];
      end else if (cmd.rd_lo) begin
         rd_addr = lo_ff[IDX_BITS-1:0];
      end else if (cmd.rd_last) begin
         rd_addr = IDX_BITS'(count_ff - CNT_BITS'(1));
      end else if (cmd.rd_shift) begin
         rd_addr = IDX_BITS'(ptr_ff - CNT_BITS'(2));
      end
   end

   always_comb begin
      wr_en   = cmd.shift_wr | cmd.new_wr;
      wr_addr = cmd.shift_wr ? ptr_ff[IDX_BITS-1:0] : lo_ff[IDX_BITS-1:0];
      wr_data = cmd.shift_wr ? rd_data : new_ff;
   end

   skt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.lo_lt_hi    = (lo_ff < hi_ff);
      sts.hit         = (lo_ff < count_ff) && (rd_data.key == new_ff.key);
      sts.is_insert   = (type_ff == REQ_INSERT);
      sts.full        = (count_ff == CNT_BITS'(CAPACITY));
      sts.lo_eq_count = (lo_ff == count_ff);
      sts.shift_last  = ((ptr_ff - CNT_BITS'(1)) == lo_ff);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      ptr_in   = ptr_ff;
      count_in = count_ff;
      if (cmd.accept) begin
         lo_in = '0;
         hi_in = count_ff;
      end
      if (cmd.probe_step) begin
         if (rd_data.key < new_ff.key) begin
            lo_in = mid + CNT_BITS'(1);
         end else begin
            hi_in = mid;
         end
      end
      if (cmd.set_ptr) begin
         ptr_in = count_ff;
      end
      if (cmd.shift_wr) begin
         ptr_in = ptr_ff - CNT_BITS'(1);
      end
      if (cmd.new_wr) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      ptr_ff <= ptr_in;
      if (cmd.accept) begin
         type_ff       <= req_type;
         new_ff.key    <= req_key;
         new_ff.kind   <= req_entry_kind;
         new_ff.handle <= req_entry_handle;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_idx_ff    <= (cmd.res_status == ST_FOUND || cmd.res_status == ST_INSERTED)
                          ? SLOT_BITS'(lo_ff) : '0;
         res_kind_ff   <= (cmd.res_status == ST_FOUND) ? rd_data.kind : '0;
         res_handle_ff <= (cmd.res_status == ST_FOUND) ? rd_data.handle : '0;
      end
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_idx_ff    <= res_idx_ff;
         out_kind_ff   <= res_kind_ff;
         out_handle_ff <= res_handle_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_slot_index   = out_idx_ff;
   assign rsp_found_kind   = out_kind_ff;
   assign rsp_found_handle = out_handle_ff;

endmodule

`default_nettype wire

[design/sorted_key_table_core.sv]
// Top level of the sorted key table: controller plus datapath.
// Depends on skt_pkg, skt_ctrl, skt_datapath (and skt_ram below it).
//
// Usage:
//  - Request channel (req_*): req_type selects find or insert; req_key is
//    the search key, req_entry_kind / req_entry_handle are stored on insert.
//  - Response channel (rsp_*): one response per request, in request order,
//    carrying status, slot index and the found entry's kind and handle.
//  - Table is held in one 512-entry RAM, kept in ascending key order.
//  - A lower-bound binary search does each probe in S_SEARCH, which reads
//    the RAM (registered read), then S_PROBE, which narrows the window;
//    p <= 10 probes at full occupancy. A find then checks the lower-bound
//    entry; the next request is taken once its result is output.
//  - An insert at position pos in a table of n entries moves (n - pos)
//    entries up one place, one entry moved per cycle through the RAM's
//    read and write ports, then writes the new entry. One request is in
//    service at a time.
//  - A finished response sits in an output register; the next request is
//    accepted and searched while it waits. If the receiver still stalls
//    when the next response is ready, the controller holds in its final
//    state until the output register frees.
//  - Reset (synchronous, active high) empties the table at once by clearing
//    the entry count; no RAM clearing pass is needed.
`default_nettype none

module sorted_key_table_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_type,
   input  wire logic [skt_pkg::KEY_BITS-1:0]        req_key,
   input  wire logic [skt_pkg::KIND_BITS-1:0]       req_entry_kind,
   input  wire logic [skt_pkg::HANDLE_BITS-1:0]     req_entry_handle,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [skt_pkg::STATUS_BITS-1:0]     rsp_status,
   output logic      [skt_pkg::SLOT_BITS-1:0]       rsp_slot_index,
   output logic      [skt_pkg::KIND_BITS-1:0]       rsp_found_kind,
   output logic      [skt_pkg::HANDLE_BITS-1:0]     rsp_found_handle
);
   import skt_pkg::*;

   cmd_type cmd;   // controller commands
   sts_type sts;   // datapath flags back to the controller

   skt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   skt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_entry_kind   (req_entry_kind),
      .req_entry_handle (req_entry_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_found_kind   (rsp_found_kind),
      .rsp_found_handle (rsp_found_handle)
   );

endmodule

`default_nettype wire

[design/skt_checker.sv]
// Port-level checks for sorted_key_table_core, attached by bind.
// Depends on skt_pkg.
`default_nettype none

module skt_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [skt_pkg::STATUS_BITS-1:0] rsp_status,
   input wire logic [skt_pkg::SLOT_BITS-1:0]   rsp_slot_index,
   input wire logic [skt_pkg::KIND_BITS-1:0]   rsp_found_kind,
   input wire logic [skt_pkg::HANDLE_BITS-1:0] rsp_found_handle
);
   import skt_pkg::*;

   // one request in service at a time
   a_one_in_service: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in service");

   // stalled response holds valid, status, slot index and handle
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_slot_index) && $stable(rsp_found_handle))
      else $error("stalled response changed");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // miss, duplicate and full carry zero fields
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_MISS || rsp_status == ST_DUPLICATE
         || rsp_status == ST_FULL)
      |-> rsp_slot_index == '0 && rsp_found_kind == '0 && rsp_found_handle == '0)
      else $error("non-zero fields on miss, duplicate or full");

   // insert reports no kind or handle
   a_insert_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED
      |-> rsp_found_kind == '0 && rsp_found_handle == '0)
      else $error("kind or handle on insert response");

endmodule

bind sorted_key_table_core skt_checker u_checker (.*);

`default_nettype wire

[tb/sv/sorted_key_table_core_tb.sv]
// Self-checking testbench for sorted_key_table_core: finds and inserts against a
// scoreboard class that keeps its own sorted copy of the table.
// Depends on skt_pkg and the sorted_key_table_core RTL only.
`timescale 1ns / 1ps

module sorted_key_table_core_tb;
   import skt_pkg::*;

   // Expected answer for one request, laid out like the response channel
   typedef struct packed {
      status_type             status;
      logic [SLOT_BITS-1:0]   slot;
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] handle;
   } table_answer_type;

   // Mirrors the table contents and queues the answer each accepted request
   // should produce.
   class sorted_table_scoreboard;
      logic [KEY_BITS-1:0]    keys[CAPACITY];
      logic [KIND_BITS-1:0]   kinds[CAPACITY];
      logic [HANDLE_BITS-1:0] handles[CAPACITY];
      int unsigned            count = 0;
      table_answer_type       pending_answers[$];
      int unsigned            mismatches = 0;
      int unsigned            answered = 0;
      int unsigned            status_seen[5] = '{default: 0};

      // first slot whose key is not below the one given
      function int unsigned lower_slot(logic [KEY_BITS-1:0] key);
         int unsigned lo;
         int unsigned hi;
         int unsigned mid;
         lo = 0;
         hi = count;
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (keys[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         return lo;
      endfunction

      function void note_request(logic op, logic [KEY_BITS-1:0] key,
                                 logic [KIND_BITS-1:0] kind,
                                 logic [HANDLE_BITS-1:0] handle);
         int unsigned      pos;
         bit               hit;
         table_answer_type ans;
         pos = lower_slot(key);
         hit = (pos < count) && (keys[pos] == key);
         ans = '0;
         if (op == REQ_FIND) begin
            if (hit) begin
               ans.status = ST_FOUND;
               ans.slot   = pos[SLOT_BITS-1:0];
               ans.kind   = kinds[pos];
               ans.handle = handles[pos];
            end else ans.status = ST_MISS;
         end else if (hit) ans.status = ST_DUPLICATE;
         else if (count >= CAPACITY) ans.status = ST_FULL;
         else begin
            for (int i = count; i > pos; i--) begin
               keys[i]    = keys[i-1];
               kinds[i]   = kinds[i-1];
               handles[i] = handles[i-1];
            end
            keys[pos]    = key;
            kinds[pos]   = kind;
            handles[pos] = handle;
            count++;
            ans.status = ST_INSERTED;
            ans.slot   = pos[SLOT_BITS-1:0];
         end
         pending_answers.push_back(ans);
      endfunction

      function void check_response(logic [STATUS_BITS-1:0] status,
                                   logic [SLOT_BITS-1:0] slot,
                                   logic [KIND_BITS-1:0] kind,
                                   logic [HANDLE_BITS-1:0] handle);
         table_answer_type want;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response with no request outstanding: ",
                         "status=%0d slot=%0d kind=%0d handle=%h"},
                        status, slot, kind, handle);
            return;
         end
         want = pending_answers.pop_front();
         answered++;
         status_seen[want.status]++;
         if (status !== want.status || slot !== want.slot ||
             kind !== want.kind || handle !== want.handle) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"ERROR: response %0d expected status=%0d slot=%0d ",
                         "kind=%0d handle=%h, got status=%0d slot=%0d ",
                         "kind=%0d handle=%h"},
                        answered, want.status, want.slot, want.kind, want.handle,
                        status, slot, kind, handle);
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 10000; // quiet cycles: worst insert plus the hold-off
   localparam int HOLD_CYCLES    = 1500;  // long receiver stall to back the block up
   localparam int DRAIN_CYCLES   = 600;   // covers the slowest insert

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_type = REQ_FIND;
   logic [KEY_BITS-1:0]     req_key = '0;
   logic [KIND_BITS-1:0]    req_entry_kind = '0;
   logic [HANDLE_BITS-1:0]  req_entry_handle = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_BITS-1:0]  rsp_status;
   logic [SLOT_BITS-1:0]    rsp_slot_index;
   logic [KIND_BITS-1:0]    rsp_found_kind;
   logic [HANDLE_BITS-1:0]  rsp_found_handle;

   sorted_table_scoreboard  table_sb;
   int unsigned             sender_idle_pct = 0;
   int unsigned             rsp_idle_pct = 0;
   int unsigned             requests_sent = 0;
   int unsigned             quiet_cycles = 0;
   int unsigned             hold_left = 0;
   logic                    hold_armed = 1'b0;
   logic                    hold_done = 1'b0;

   sorted_key_table_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_key          (req_key),
      .req_entry_kind   (req_entry_kind),
      .req_entry_handle (req_entry_handle),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_found_kind   (rsp_found_kind),
      .rsp_found_handle (rsp_found_handle)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request, idling first at the current sender rate. Returns at
   // the edge where the request was taken, after noting it in the scoreboard,
   // so the next request can be chosen from the updated table.
   task automatic send_request(input logic op, input logic [KEY_BITS-1:0] key,
                               input logic [KIND_BITS-1:0] kind,
                               input logic [HANDLE_BITS-1:0] handle);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_type         <= op;
      req_key          <= key;
      req_entry_kind   <= kind;
      req_entry_handle <= handle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      table_sb.note_request(op, key, kind, handle);
      requests_sent++;
   endtask

   // Random find or insert. Keys are drawn from the table itself (hits and
   // duplicates), from its neighbours, from either end of the key range, or
   // from the whole range. Finds lean harder on present keys.
   task automatic random_request(input int unsigned insert_pct);
      logic                op;
      logic [KEY_BITS-1:0] key;
      int unsigned         pick;
      int unsigned         reuse_limit;
      op = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_FIND;
      pick = $urandom_range(9);
      reuse_limit = (op == REQ_INSERT) ? 2 : 4;
      if (table_sb.count != 0 && pick < reuse_limit)
         key = table_sb.keys[$urandom_range(table_sb.count - 1)];
      else if (table_sb.count != 0 && pick == reuse_limit)
         key = table_sb.keys[$urandom_range(table_sb.count - 1)] ^ 32'h1;
      else if (pick == reuse_limit + 1)
         key = $urandom_range(1) ? 32'($urandom_range(7)) : ~32'($urandom_range(7));
      else
         key = $urandom;
      send_request(op, key, 2'($urandom_range(3)), $urandom);
   endtask

   // Receiver: random stalls at the current rate, plus one long hold-off
   // counted here once the main sequence arms it.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         table_sb.check_response(rsp_status, rsp_slot_index, rsp_found_kind,
                                 rsp_found_handle);
   end

   // Watchdog: counts edges at which neither channel moves
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("ERROR: no request or response moved for %0d cycles", WATCHDOG_LIMIT);
         $display("sorted_key_table_core_tb NOT OK");
         $finish;
      end
   end

   initial begin
      table_sb = new;
      sender_idle_pct = 22;
      rsp_idle_pct    = 76;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, key and handle extremes, insert at the front
      // (shifts everything up), duplicate, kind 3 stored and read back,
      // misses between present keys, find with junk insert fields.
      send_request(REQ_FIND,   32'h0000_0000, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'hFFFF_FFFF, 2'd3, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h8000_0000, 2'd0, 32'h0000_0000);
      send_request(REQ_INSERT, 32'hFFFF_FFFF, 2'd1, 32'hFFFF_FFFF);
      send_request(REQ_INSERT, 32'h0000_0000, 2'd2, 32'hA5A5_A5A5);
      send_request(REQ_INSERT, 32'h7FFF_FFFF, 2'd3, 32'h5A5A_5A5A);
      send_request(REQ_INSERT, 32'h8000_0000, 2'd1, 32'h1234_5678);
      send_request(REQ_FIND,   32'h0000_0000, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'hFFFF_FFFF, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'h7FFF_FFFF, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'h8000_0001, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'h0000_0001, 2'd0, 32'h0000_0000);
      send_request(REQ_INSERT, 32'h0000_0001, 2'd2, 32'h8000_0001);
      send_request(REQ_FIND,   32'h8000_0000, 2'd3, 32'hDEAD_BEEF);
      send_request(REQ_INSERT, 32'hFFFF_FFFE, 2'd1, 32'h0000_0001);
      send_request(REQ_FIND,   32'hFFFF_FFFE, 2'd0, 32'h0000_0000);
      send_request(REQ_FIND,   32'h0000_0001, 2'd1, 32'h0000_0000);

      // Slow receiver
      repeat (400) random_request(60);

      // Slow sender
      sender_idle_pct = 76;
      rsp_idle_pct    = 22;
      repeat (400) random_request(60);

      // Full rate; the receiver's long hold-off lands here while requests keep
      // coming. Fill to capacity, then hit the full and duplicate paths.
      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      hold_armed <= 1'b1;
      while (table_sb.count < CAPACITY) random_request(85);
      repeat (100) random_request(60);
      req_valid <= 1'b0;

      while (table_sb.pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d found, %0d missed, %0d inserted, %0d duplicate, %0d full",
               requests_sent, table_sb.status_seen[ST_FOUND], table_sb.status_seen[ST_MISS],
               table_sb.status_seen[ST_INSERTED], table_sb.status_seen[ST_DUPLICATE],
               table_sb.status_seen[ST_FULL]);
      $display({"Table filled to %0d of %0d entries under three stall mixes ",
                "and one long hold-off; %0d mismatches"},
               table_sb.count, CAPACITY, table_sb.mismatches);
      if (table_sb.mismatches == 0 && table_sb.pending_answers.size() == 0) begin
         $display("sorted_key_table_core_tb OK");
      end else begin
         $display("sorted_key_table_core_tb NOT OK");
      end
      $finish;
   end

endmodule

[files.f]
design/skt_pkg.sv
design/skt_ram.sv
design/skt_ctrl.sv
design/skt_datapath.sv
design/sorted_key_table_core.sv
design/skt_checker.sv
tb/sv/sorted_key_table_core_tb.sv
